// ===== hdl/sds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg: shared definitions for the saturating duration scaler
// Request codes, limits, pipeline payload types and the divider step.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int FRACT_BITS_DEF = 16;
  localparam int DIV_STAGES     = 16;
  localparam int STEP_BITS      = 4;

  localparam logic [1:0] REQ_SCALE = 2'd0;
  localparam logic [1:0] REQ_MUL   = 2'd1;
  localparam logic [1:0] REQ_DIV   = 2'd2;

  localparam logic [63:0] POS_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [95:0] num;
    logic [31:0] divisor;
    logic        neg;
    logic        dz;
    logic        nul;
  } num_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] quo;
    logic [31:0] divisor;
    logic        neg;
    logic        dz;
    logic        nul;
    logic        ovf;
  } quo_t;

  // Restoring division, STEP_BITS quotient bits per call.
  function automatic quo_t div_step(quo_t s);
    quo_t        r;
    logic [32:0] t;
    r = s;
    for (int i = 0; i < STEP_BITS; i++) begin
      t     = {r.rem, r.quo[63]};
      r.quo = {r.quo[62:0], 1'b0};
      if (t >= {1'b0, r.divisor}) begin
        t        = t - {1'b0, r.divisor};
        r.quo[0] = 1'b1;
      end
      r.rem = t[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/sds_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_if: request and result channels
// Valid/ready channels carrying the request operands and the result.
// ----------------------------------------------------------------------------
interface sds_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [63:0] duration_in;
  logic signed [31:0] factor_a;
  logic signed [31:0] factor_b;
  modport source(output valid, req_type, duration_in, factor_a, factor_b, input ready);
  modport sink(input valid, req_type, duration_in, factor_a, factor_b, output ready);
endinterface

interface sds_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result;
  logic               saturated;
  logic               divide_by_zero;
  modport source(output valid, result, saturated, divide_by_zero, input ready);
  modport sink(input valid, result, saturated, divide_by_zero, output ready);
endinterface

// ===== hdl/sds_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_front: operand decode and product
// Takes magnitudes, picks multiplier and divisor, forms the 96-bit numerator.
// ----------------------------------------------------------------------------
module sds_front #(
  parameter int FRACT_BITS = sds_pkg::FRACT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [63:0]         duration_in,
  input  logic [31:0]         factor_a,
  input  logic [31:0]         factor_b,
  output logic                out_valid,
  input  logic                out_ready,
  output sds_pkg::num_t       out_data
);

  typedef struct packed {
    logic [63:0] dmag;
    logic [31:0] mul;
    logic [31:0] divisor;
    logic        neg;
    logic        dz;
    logic        nul;
  } opa_t;

  typedef struct packed {
    logic [63:0] p0;
    logic [63:0] p1;
    logic [31:0] divisor;
    logic        neg;
    logic        dz;
    logic        nul;
  } prod_t;

  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRACT_BITS);

  logic [2:0]    vld_r;
  logic [3:0]    en;
  opa_t          a_r, a_nxt;
  prod_t         b_r, b_nxt;
  sds_pkg::num_t c_r, c_nxt;

  always_comb begin
    en[3] = out_ready;
    for (int i = 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[2];
  assign out_data  = c_r;

  always_comb begin
    logic        dneg, aneg, bneg;
    logic [31:0] amag, bmag;
    dneg = duration_in[63];
    aneg = factor_a[31];
    bneg = factor_b[31];
    amag = aneg ? (~factor_a + 32'd1) : factor_a;
    bmag = bneg ? (~factor_b + 32'd1) : factor_b;
    a_nxt.dmag    = dneg ? (~duration_in + 64'd1) : duration_in;
    a_nxt.neg     = dneg ^ aneg;
    a_nxt.dz      = 1'b0;
    a_nxt.nul     = 1'b0;
    a_nxt.mul     = '0;
    a_nxt.divisor = 32'd1;
    case (req_type)
      sds_pkg::REQ_SCALE: begin
        a_nxt.neg     = dneg ^ aneg ^ bneg;
        a_nxt.mul     = bmag;
        a_nxt.divisor = amag;
        a_nxt.dz      = (amag == '0);
      end
      sds_pkg::REQ_MUL: begin
        a_nxt.mul     = amag;
        a_nxt.divisor = ONE_FX;
      end
      sds_pkg::REQ_DIV: begin
        a_nxt.mul     = ONE_FX;
        a_nxt.divisor = amag;
        a_nxt.dz      = (amag == '0);
      end
      default: begin
        a_nxt.nul = 1'b1;
      end
    endcase
    if (a_nxt.dz) begin
      a_nxt.divisor = 32'd1;
    end
  end

  always_comb begin
    b_nxt.p0      = {32'd0, a_r.dmag[31:0]} * {32'd0, a_r.mul};
    b_nxt.p1      = {32'd0, a_r.dmag[63:32]} * {32'd0, a_r.mul};
    b_nxt.divisor = a_r.divisor;
    b_nxt.neg     = a_r.neg;
    b_nxt.dz      = a_r.dz;
    b_nxt.nul     = a_r.nul;
  end

  always_comb begin
    c_nxt.num     = {32'd0, b_r.p0} + {b_r.p1, 32'd0};
    c_nxt.divisor = b_r.divisor;
    c_nxt.neg     = b_r.neg;
    c_nxt.dz      = b_r.dz;
    c_nxt.nul     = b_r.nul;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) a_r <= a_nxt;
    if (en[1]) b_r <= b_nxt;
    if (en[2]) c_r <= c_nxt;
  end

endmodule

// ===== hdl/sds_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_div: pipelined restoring divider
// Divides the 96-bit numerator by a 32-bit divisor, a few bits per stage.
// ----------------------------------------------------------------------------
module sds_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sds_pkg::num_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sds_pkg::quo_t out_data
);

  localparam int N = sds_pkg::DIV_STAGES;

  logic [N-1:0]  vld_r;
  logic [N:0]    en;
  sds_pkg::quo_t st_r [N];
  sds_pkg::quo_t head;

  always_comb begin
    en[N] = out_ready;
    for (int i = N - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  // The quotient overflows 64 bits exactly when the top word reaches the divisor.
  always_comb begin
    head.rem     = in_data.num[95:64];
    head.quo     = in_data.num[63:0];
    head.divisor = in_data.divisor;
    head.neg     = in_data.neg;
    head.dz      = in_data.dz;
    head.nul     = in_data.nul;
    head.ovf     = (in_data.num[95:64] >= in_data.divisor);
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[N-1];
  assign out_data  = st_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) st_r[0] <= sds_pkg::div_step(head);
    for (int i = 1; i < N; i++) begin
      if (en[i]) st_r[i] <= sds_pkg::div_step(st_r[i-1]);
    end
  end

endmodule

// ===== hdl/sds_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_back: sign and saturation
// Applies the sign, clamps to the signed 64-bit limits, holds the result.
// ----------------------------------------------------------------------------
module sds_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sds_pkg::quo_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   result,
  output logic          saturated,
  output logic          divide_by_zero
);

  logic        vld_r;
  logic [63:0] res_r, res_nxt;
  logic        sat_r, sat_nxt;
  logic        dz_r, dz_nxt;

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    res_nxt = '0;
    sat_nxt = 1'b0;
    dz_nxt  = 1'b0;
    if (in_data.nul) begin
      res_nxt = '0;
    end else if (in_data.dz) begin
      res_nxt = sds_pkg::POS_MAX;
      dz_nxt  = 1'b1;
    end else if (!in_data.neg) begin
      if (in_data.ovf || in_data.quo[63]) begin
        res_nxt = sds_pkg::POS_MAX;
        sat_nxt = 1'b1;
      end else begin
        res_nxt = in_data.quo;
      end
    end else begin
      if (in_data.ovf || in_data.quo > sds_pkg::NEG_MIN) begin
        res_nxt = sds_pkg::NEG_MIN;
        sat_nxt = 1'b1;
      end else begin
        res_nxt = ~in_data.quo + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
      dz_r  <= dz_nxt;
    end
  end

  assign out_valid      = vld_r;
  assign result         = res_r;
  assign saturated      = sat_r;
  assign divide_by_zero = dz_r;

endmodule

// ===== hdl/sat_duration_scale_64.sv =====
`timescale 1ns / 1ps
// Path: 3 front registers, the 16-stage divider, then 1 output register.
// Throughput: one request per cycle when not stalled; 4 quotient bits per stage.
// Each stage holds its item until the next stage frees, so stalls lose nothing.
// Reset: synchronous, active low; clears all valid bits, the pipeline empties.
// ----------------------------------------------------------------------------
// sat_duration_scale_64: saturating signed 64-bit duration scaler
// Scale by to/from, multiply or divide by a fixed-point fraction.
// ----------------------------------------------------------------------------
module sat_duration_scale_64 #(
  parameter int FRACT_BITS = sds_pkg::FRACT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sds_in_if.sink    in_ch,
  sds_out_if.source out_ch
);

  logic          f_valid, f_ready;
  sds_pkg::num_t f_data;
  logic          d_valid, d_ready;
  sds_pkg::quo_t d_data;
  logic [63:0]   res;

  sds_front #(.FRACT_BITS(FRACT_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .req_type    (in_ch.req_type),
    .duration_in (in_ch.duration_in),
    .factor_a    (in_ch.factor_a),
    .factor_b    (in_ch.factor_b),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_data    (f_data)
  );

  sds_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  sds_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (d_valid),
    .in_ready       (d_ready),
    .in_data        (d_data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .result         (res),
    .saturated      (out_ch.saturated),
    .divide_by_zero (out_ch.divide_by_zero)
  );

  assign out_ch.result = res;

  a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.divide_by_zero |->
      !out_ch.saturated && res == sds_pkg::POS_MAX)
    else $error("divide by zero without positive maximum");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      res == sds_pkg::POS_MAX || res == sds_pkg::NEG_MIN)
    else $error("saturated result is not a limit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule
